[rtl/smgc_pkg.sv]
package smgc_pkg;

   // default geometry
   localparam int MAX_DIM_DEF    = 64;
   localparam int COORD_BITS_DEF = 16;

   // request commands
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_LOAD_X   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_Y   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_Z   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLASSIFY = 3'd4;

   // control registers
   localparam int SIZE_W     = 7;
   localparam int RADIUS_W   = 15;
   localparam int R2_W       = 2 * RADIUS_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS = 2'd3;
   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 7'd64;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd3277;

   // result
   localparam int COUNT_W = 19;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic KIND_ACTIVE = 1'b0;
   localparam logic KIND_GHOST  = 1'b1;

   // probe sequencing: center, then 27 neighborhood offsets
   localparam int NPROBE   = 28;
   localparam int PIPE_LAT = 3;
   localparam int STEP_W   = 5;
   localparam logic [STEP_W-1:0] PROBE_LAST = STEP_W'(NPROBE - 1);
   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NPROBE - 1 + PIPE_LAT);
   localparam int OFF_W = 2;
   localparam logic [OFF_W-1:0] OFF_MID = 2'd1;
   localparam logic [OFF_W-1:0] OFF_MAX = 2'd2;

   typedef struct packed {
      logic valid;
      logic center;
      logic inb;
   } probe_tag_type;

endpackage

[rtl/smgc_ifs.sv]
interface smgc_req_if #(
   parameter int IDX_W      = 6,
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [smgc_pkg::CMD_W-1:0]   command;
   logic [IDX_W-1:0]             index;
   logic signed [COORD_BITS-1:0] coordinate;
   logic [IDX_W-1:0]             cell_i;
   logic [IDX_W-1:0]             cell_j;
   logic [IDX_W-1:0]             cell_k;

   modport source (output valid, command, index, coordinate, cell_i, cell_j, cell_k,
                   input ready);
   modport sink   (input valid, command, index, coordinate, cell_i, cell_j, cell_k,
                   output ready);
endinterface

interface smgc_rsp_if #(
   parameter int IDX_W      = 6,
   parameter int COORD_BITS = 16
);
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [IDX_W-1:0]               at_i;
   logic [IDX_W-1:0]               at_j;
   logic [IDX_W-1:0]               at_k;
   logic signed [COORD_BITS-1:0]   x_value;
   logic signed [COORD_BITS-1:0]   y_value;
   logic signed [COORD_BITS-1:0]   z_value;
   logic [smgc_pkg::COUNT_W-1:0]   active_total;
   logic [smgc_pkg::COUNT_W-1:0]   ghost_total;

   modport source (output valid, kind, at_i, at_j, at_k, x_value, y_value, z_value,
                   active_total, ghost_total, input ready);
   modport sink   (input valid, kind, at_i, at_j, at_k, x_value, y_value, z_value,
                   active_total, ghost_total, output ready);
endinterface

interface smgc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [smgc_pkg::CSR_IDX_W-1:0]  index;
   logic [smgc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/smgc_ram.sv]
module smgc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sphere_mask_ghost_cell_classifier.sv]
// Sphere mask ghost cell classifier.
//
// req_bus   requests: load one entry of the x, y or z coordinate table (signed
//           Q3.12), clear the running counts, or classify cell (i, j, k).
// rsp_bus   one result per classified cell that is active (inside the sphere)
//           or ghost (outside, with an active cell in its 3x3x3 neighborhood).
//           Other classify requests, out-of-range cells, loads and clears give none.
// csr_bus   sizes along x, y, z and the radius; always ready, write while idle.
//
// Loads and clears leave the sequencer idle. A classify runs 28 probes (the cell,
// then all 27 neighborhood positions) through one shared square-sum compare unit,
// one probe per cycle, each passing the table read, square and sum registers, and
// ends in a decision state that may load the result register. req_bus.ready is
// low from the acceptance of a classify until the sequencer is back in idle.
// The result sits in an output register: the next request is taken while it
// waits. If a new result is due while the old one is still held, the
// sequencer waits in its decision state until rsp_bus.ready frees the slot.
//
// Reset (synchronous) clears counts, sequencer and output valid and restores
// sizes to 64 and radius to 3277; the tables hold no defined value until loaded.
module sphere_mask_ghost_cell_classifier #(
   parameter int MAX_DIM    = smgc_pkg::MAX_DIM_DEF,
   parameter int COORD_BITS = smgc_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   smgc_req_if.sink    req_bus,
   smgc_rsp_if.source  rsp_bus,
   smgc_csr_if.sink    csr_bus
);

   import smgc_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   // one spare bit so an underflowed position reads as far out of range
   localparam int EXT_W = ((SIZE_W > DIM_W) ? SIZE_W : DIM_W) + 1;
   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 2;
   localparam int CMP_W = (SUM_W > R2_W) ? SUM_W : R2_W;
   localparam logic [EXT_W-1:0] DIM_LIMIT = EXT_W'(MAX_DIM);

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
   localparam logic [ST_W-1:0] ST_RUN  = 2'd1;
   localparam logic [ST_W-1:0] ST_DONE = 2'd2;

   function automatic logic [EXT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [EXT_W-1:0] se;
      se = EXT_W'(s);
      return (se > DIM_LIMIT) ? DIM_LIMIT : se;
   endfunction

   // index + offset - 1; wraps to all ones below zero
   function automatic logic [EXT_W-1:0] axis_pos(input logic [IDX_W-1:0] idx,
                                                 input logic [OFF_W-1:0] off);
      return EXT_W'(idx) + EXT_W'(off) - EXT_W'(1);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

   // ---------------- control registers ----------------
   logic [SIZE_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [R2_W-1:0]     r2_ff;
   logic                csr_fire;

   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_fire) begin
         unique case (csr_bus.index)
            REG_SIZE_X: size_x_ff <= csr_bus.data[SIZE_W-1:0];
            REG_SIZE_Y: size_y_ff <= csr_bus.data[SIZE_W-1:0];
            REG_SIZE_Z: size_z_ff <= csr_bus.data[SIZE_W-1:0];
            REG_RADIUS: radius_ff <= csr_bus.data[RADIUS_W-1:0];
         endcase
      end
   end

   // radius squared, refreshed every cycle; the user must move config only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      r2_ff <= R2_W'(radius_ff) * R2_W'(radius_ff);
   end

   logic [EXT_W-1:0] eff_x, eff_y, eff_z;
   assign eff_x = eff_size(size_x_ff);
   assign eff_y = eff_size(size_y_ff);
   assign eff_z = eff_size(size_z_ff);

   // ---------------- sequencer state ----------------
   logic [ST_W-1:0]   state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [OFF_W-1:0]  off_x_ff, off_x_in, off_y_ff, off_y_in, off_z_ff, off_z_in;
   logic [IDX_W-1:0]  cell_i_ff, cell_i_in, cell_j_ff, cell_j_in, cell_k_ff, cell_k_in;
   logic              act_ff, act_in, nb_ff, nb_in;
   logic [COUNT_W-1:0] active_cnt_ff, active_cnt_in, ghost_cnt_ff, ghost_cnt_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;
   logic                         rsp_kind_ff;
   logic [IDX_W-1:0]             rsp_at_i_ff, rsp_at_j_ff, rsp_at_k_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [COUNT_W-1:0]           rsp_active_total_ff, rsp_ghost_total_ff;

   logic req_fire;
   logic cell_ok;
   logic rsp_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign cell_ok       = (EXT_W'(req_bus.cell_i) < eff_x) &&
                          (EXT_W'(req_bus.cell_j) < eff_y) &&
                          (EXT_W'(req_bus.cell_k) < eff_z);

   // ---------------- probe address generation ----------------
   logic             issue, is_center;
   logic [OFF_W-1:0] ox, oy, oz;
   logic [EXT_W-1:0] px, py, pz;
   probe_tag_type    tag0, tag1_ff, tag2_ff, tag3_ff;

   assign issue     = (state_ff == ST_RUN) && (step_ff <= PROBE_LAST);
   assign is_center = (step_ff == '0);
   assign ox        = is_center ? OFF_MID : off_x_ff;
   assign oy        = is_center ? OFF_MID : off_y_ff;
   assign oz        = is_center ? OFF_MID : off_z_ff;
   assign px        = axis_pos(cell_i_ff, ox);
   assign py        = axis_pos(cell_j_ff, oy);
   assign pz        = axis_pos(cell_k_ff, oz);

   assign tag0.valid  = issue;
   assign tag0.center = is_center;
   assign tag0.inb    = (px < eff_x) && (py < eff_y) && (pz < eff_z);

   // ---------------- coordinate tables ----------------
   logic                 load_ok;
   logic                 wr_x, wr_y, wr_z;
   logic [COORD_BITS-1:0] x_rd, y_rd, z_rd;

   assign load_ok = req_fire && (EXT_W'(req_bus.index) < DIM_LIMIT);
   assign wr_x    = load_ok && (req_bus.command == CMD_LOAD_X);
   assign wr_y    = load_ok && (req_bus.command == CMD_LOAD_Y);
   assign wr_z    = load_ok && (req_bus.command == CMD_LOAD_Z);

   smgc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_DIM)) u_x_table (
      .clock   (clock),
      .wr_en   (wr_x),
      .wr_addr (req_bus.index),
      .wr_data (req_bus.coordinate),
      .rd_addr (px[IDX_W-1:0]),
      .rd_data (x_rd)
   );

   smgc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_DIM)) u_y_table (
      .clock   (clock),
      .wr_en   (wr_y),
      .wr_addr (req_bus.index),
      .wr_data (req_bus.coordinate),
      .rd_addr (py[IDX_W-1:0]),
      .rd_data (y_rd)
   );

   smgc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_DIM)) u_z_table (
      .clock   (clock),
      .wr_en   (wr_z),
      .wr_addr (req_bus.index),
      .wr_data (req_bus.coordinate),
      .rd_addr (pz[IDX_W-1:0]),
      .rd_data (z_rd)
   );

   // ---------------- shared square-sum compare unit ----------------
   logic signed [COORD_BITS-1:0] xs, ys, zs;
   logic signed [SQ_W-1:0]       sq_x, sq_y, sq_z;
   logic [SQ_W-1:0]              sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SUM_W-1:0]             sum_ff;
   logic signed [COORD_BITS-1:0] cen_x_ff, cen_y_ff, cen_z_ff;
   logic                         hit;

   assign xs   = $signed(x_rd);
   assign ys   = $signed(y_rd);
   assign zs   = $signed(z_rd);
   assign sq_x = xs * xs;
   assign sq_y = ys * ys;
   assign sq_z = zs * zs;

   // squares are never negative, so the exact sum compares unsigned
   assign hit = tag3_ff.valid && tag3_ff.inb && (CMP_W'(sum_ff) < CMP_W'(r2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x;
      sq_y_ff <= sq_y;
      sq_z_ff <= sq_z;
      sum_ff  <= SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
      if (tag1_ff.valid && tag1_ff.center) begin
         cen_x_ff <= xs;
         cen_y_ff <= ys;
         cen_z_ff <= zs;
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      off_x_in      = off_x_ff;
      off_y_in      = off_y_ff;
      off_z_in      = off_z_ff;
      cell_i_in     = cell_i_ff;
      cell_j_in     = cell_j_ff;
      cell_k_in     = cell_k_ff;
      act_in        = act_ff;
      nb_in         = nb_ff;
      active_cnt_in = active_cnt_ff;
      ghost_cnt_in  = ghost_cnt_ff;
      rsp_load      = 1'b0;

      // collect compare outcomes as they leave the unit
      if (tag3_ff.valid) begin
         if (tag3_ff.center) begin
            act_in = hit;
         end else begin
            nb_in = nb_ff || hit;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.command == CMD_CLEAR) begin
                  active_cnt_in = '0;
                  ghost_cnt_in  = '0;
               end else if (req_bus.command == CMD_CLASSIFY && cell_ok) begin
                  state_in  = ST_RUN;
                  step_in   = '0;
                  off_x_in  = '0;
                  off_y_in  = '0;
                  off_z_in  = '0;
                  cell_i_in = req_bus.cell_i;
                  cell_j_in = req_bus.cell_j;
                  cell_k_in = req_bus.cell_k;
                  act_in    = 1'b0;
                  nb_in     = 1'b0;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            // odometer over the 3x3x3 offsets, z fastest
            if (issue && !is_center) begin
               if (off_z_ff == OFF_MAX) begin
                  off_z_in = '0;
                  if (off_y_ff == OFF_MAX) begin
                     off_y_in = '0;
                     off_x_in = off_x_ff + OFF_W'(1);
                  end else begin
                     off_y_in = off_y_ff + OFF_W'(1);
                  end
               end else begin
                  off_z_in = off_z_ff + OFF_W'(1);
               end
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!act_ff && !nb_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (act_ff) begin
                  active_cnt_in = sat_inc(active_cnt_ff);
               end else begin
                  ghost_cnt_in = sat_inc(ghost_cnt_ff);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         off_x_ff      <= '0;
         off_y_ff      <= '0;
         off_z_ff      <= '0;
         act_ff        <= 1'b0;
         nb_ff         <= 1'b0;
         active_cnt_ff <= '0;
         ghost_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         off_x_ff      <= off_x_in;
         off_y_ff      <= off_y_in;
         off_z_ff      <= off_z_in;
         act_ff        <= act_in;
         nb_ff         <= nb_in;
         active_cnt_ff <= active_cnt_in;
         ghost_cnt_ff  <= ghost_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_i_ff <= cell_i_in;
      cell_j_ff <= cell_j_in;
      cell_k_ff <= cell_k_in;
      if (rsp_load) begin
         rsp_kind_ff         <= act_ff ? KIND_ACTIVE : KIND_GHOST;
         rsp_at_i_ff         <= cell_i_ff;
         rsp_at_j_ff         <= cell_j_ff;
         rsp_at_k_ff         <= cell_k_ff;
         // ghost cells report no coordinates
         rsp_x_ff            <= act_ff ? cen_x_ff : '0;
         rsp_y_ff            <= act_ff ? cen_y_ff : '0;
         rsp_z_ff            <= act_ff ? cen_z_ff : '0;
         rsp_active_total_ff <= active_cnt_in;
         rsp_ghost_total_ff  <= ghost_cnt_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_kind_ff;
   assign rsp_bus.at_i         = rsp_at_i_ff;
   assign rsp_bus.at_j         = rsp_at_j_ff;
   assign rsp_bus.at_k         = rsp_at_k_ff;
   assign rsp_bus.x_value      = rsp_x_ff;
   assign rsp_bus.y_value      = rsp_y_ff;
   assign rsp_bus.z_value      = rsp_z_ff;
   assign rsp_bus.active_total = rsp_active_total_ff;
   assign rsp_bus.ghost_total  = rsp_ghost_total_ff;

   // ---------------- checks ----------------
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (step_ff == LAST_STEP) |=> (state_ff == ST_DONE))
      else $error("sequencer did not reach decision after last probe");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside decision cycle");

   a_active_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_ACTIVE) |-> (rsp_active_total_ff != '0))
      else $error("active result with zero active total");

endmodule
